// File: hdl/cbd_pkg.sv
package cbd_pkg;

    localparam int unsigned MAX_CELLS_DEF = 18;

    localparam int unsigned VOLT_W = 16;
    localparam int unsigned NCELL_W = 5;
    localparam int unsigned MASK_W = 18;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CELLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BAL = 2'd2;

    localparam logic [NCELL_W-1:0] NUM_CELLS_RST = 5'd18;
    localparam logic [VOLT_W-1:0] THRESHOLD_RST = 16'd10;
    localparam logic [VOLT_W-1:0] MIN_BAL_RST = 16'd3000;
    localparam logic [VOLT_W-1:0] VOLT_ALL_ONES = 16'hFFFF;

    localparam int unsigned PC_W = 2;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_WAIT = 2'd0;
    localparam t_pc PC_CHECK = 2'd1;
    localparam t_pc PC_WALK_INIT = 2'd2;
    localparam t_pc PC_EMIT = 2'd3;

    typedef enum logic [1:0] {
        COND_START,
        COND_FULL,
        COND_LAST,
        COND_ALWAYS
    } t_cond;

    typedef struct packed {
        logic  idle;
        logic  walk_init;
        logic  emit;
        t_cond cond;
        t_pc   jump_pc;
        t_pc   next_pc;
    } t_uop;

    function automatic t_uop ucode_rom(input t_pc pc);
        t_uop u;
        u = '{idle: 1'b0, walk_init: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
              jump_pc: PC_WAIT, next_pc: PC_WAIT};
        case (pc)
            PC_WAIT: begin
                u.idle = 1'b1;
                u.cond = COND_START;
                u.jump_pc = PC_CHECK;
                u.next_pc = PC_WAIT;
            end
            PC_CHECK: begin
                u.cond = COND_FULL;
                u.jump_pc = PC_WALK_INIT;
                u.next_pc = PC_WAIT;
            end
            PC_WALK_INIT: begin
                u.walk_init = 1'b1;
                u.cond = COND_ALWAYS;
                u.jump_pc = PC_EMIT;
                u.next_pc = PC_EMIT;
            end
            PC_EMIT: begin
                u.emit = 1'b1;
                u.cond = COND_LAST;
                u.jump_pc = PC_WAIT;
                u.next_pc = PC_EMIT;
            end
            default: begin
                u.cond = COND_ALWAYS;
            end
        endcase
        return u;
    endfunction

endpackage

// File: hdl/cell_balance_decider_top.sv
// Loading a cell voltage stores it in the wait state, then checks the round count in the check state.
// The beat that completes a round is followed by the check state and one setup state, then one
// result beat per loaded cell on consecutive cycles.
// The walk is paced by the single read port of the cell store. Results cannot be stalled.
// Synchronous active-low reset clears the round state and restores the register defaults.
module cell_balance_decider_top #(
    parameter int unsigned MAX_CELLS = cbd_pkg::MAX_CELLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [cbd_pkg::VOLT_W-1:0]      i_cell_voltage,
    output logic                            o_valid,
    output logic [cbd_pkg::NCELL_W-1:0]     o_cell_index,
    output logic                            o_discharge,
    output logic [cbd_pkg::VOLT_W-1:0]      o_min_voltage,
    output logic [cbd_pkg::VOLT_W-1:0]      o_max_voltage,
    output logic [cbd_pkg::MASK_W-1:0]      o_discharge_mask,
    output logic                            o_last_result
);
    import cbd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_CELLS + 1);
    localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    logic [VOLT_W-1:0] mem [MAX_CELLS];

    logic [NCELL_W-1:0] r_cfg_num;
    logic [VOLT_W-1:0]  r_cfg_thr;
    logic [VOLT_W-1:0]  r_cfg_minbal;

    t_pc               r_pc;
    logic [CW-1:0]     r_loaded;
    logic [VOLT_W-1:0] r_min;
    logic [VOLT_W-1:0] r_max;
    logic [MASK_W-1:0] r_mask;
    logic [AW-1:0]     r_k;
    logic [VOLT_W-1:0] r_rd_data;

    t_uop              uop;
    logic              cond_true;
    t_pc               n_pc;
    logic [5:0]        eff_count;
    logic              full;
    logic              last;
    logic [VOLT_W:0]   limit;
    logic              dis;
    logic [MASK_W-1:0] n_mask;
    logic              load;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    assign uop = ucode_rom(r_pc);
    assign busy = !uop.idle;
    assign load = uop.idle && start;

    always_comb begin
        if (r_cfg_num == '0) begin
            eff_count = 6'd1;
        end else if ({1'b0, r_cfg_num} > 6'(MAX_CELLS)) begin
            eff_count = 6'(MAX_CELLS);
        end else begin
            eff_count = {1'b0, r_cfg_num};
        end
    end

    assign full = 6'(r_loaded) >= eff_count;
    assign last = (CW'(r_k) + CW'(1)) == r_loaded;

    always_comb begin
        case (uop.cond)
            COND_START:  cond_true = start;
            COND_FULL:   cond_true = full;
            COND_LAST:   cond_true = last;
            COND_ALWAYS: cond_true = 1'b1;
            default:     cond_true = 1'b1;
        endcase
        n_pc = cond_true ? uop.jump_pc : uop.next_pc;
    end

    assign limit = {1'b0, r_min} + {1'b0, r_cfg_thr};
    assign dis = (r_rd_data > r_cfg_minbal) && ({1'b0, r_rd_data} > limit);
    assign n_mask = r_mask | (MASK_W'(dis) << r_k);

    assign rd_en = uop.walk_init || (uop.emit && !last);
    assign rd_addr = uop.walk_init ? '0 : r_k + AW'(1);

    always_ff @(posedge i_clk) begin
        if (load && (r_loaded < CW'(MAX_CELLS))) begin
            mem[r_loaded[AW-1:0]] <= i_cell_voltage;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_num <= NUM_CELLS_RST;
            r_cfg_thr <= THRESHOLD_RST;
            r_cfg_minbal <= MIN_BAL_RST;
            r_pc <= PC_WAIT;
            r_loaded <= '0;
            r_min <= VOLT_ALL_ONES;
            r_max <= '0;
            r_mask <= '0;
            r_k <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_CELLS: r_cfg_num <= i_cfg_data[NCELL_W-1:0];
                    CFG_THRESHOLD: r_cfg_thr <= i_cfg_data;
                    CFG_MIN_BAL:   r_cfg_minbal <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_pc <= n_pc;
            o_valid <= uop.emit;
            if (load) begin
                if (i_cell_voltage < r_min) begin
                    r_min <= i_cell_voltage;
                end
                if (i_cell_voltage > r_max) begin
                    r_max <= i_cell_voltage;
                end
                if (r_loaded < CW'(MAX_CELLS)) begin
                    r_loaded <= r_loaded + CW'(1);
                end
            end
            if (uop.walk_init) begin
                r_mask <= '0;
                r_k <= '0;
            end
            if (uop.emit) begin
                r_mask <= n_mask;
                r_k <= r_k + AW'(1);
                if (last) begin
                    r_loaded <= '0;
                    r_min <= VOLT_ALL_ONES;
                    r_max <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (uop.emit) begin
            o_cell_index <= NCELL_W'(r_k);
            o_discharge <= dis;
            o_min_voltage <= r_min;
            o_max_voltage <= r_max;
            o_discharge_mask <= n_mask;
            o_last_result <= last;
        end
    end

endmodule

// File: sim/cell_balance_decider_top_tb.sv
`timescale 1ns / 100ps

module cell_balance_decider_top_tb;
    import cbd_pkg::*;

    localparam int unsigned NCELLS = MAX_CELLS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 24;
    localparam int unsigned RANDOM_CELLS = 144;

    typedef struct packed {
        logic [NCELL_W-1:0] cell_index;
        logic               discharge;
        logic [VOLT_W-1:0]  min_voltage;
        logic [VOLT_W-1:0]  max_voltage;
        logic [MASK_W-1:0]  discharge_mask;
        logic               last_result;
    } t_decision;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic                  busy;
    logic [VOLT_W-1:0]     i_cell_voltage;
    logic                  o_valid;
    logic [NCELL_W-1:0]    o_cell_index;
    logic                  o_discharge;
    logic [VOLT_W-1:0]     o_min_voltage;
    logic [VOLT_W-1:0]     o_max_voltage;
    logic [MASK_W-1:0]     o_discharge_mask;
    logic                  o_last_result;

    t_decision         pending_decisions[$];
    logic [VOLT_W-1:0] pack_cells[NCELLS];
    int unsigned       pack_loaded;
    logic [VOLT_W-1:0] pack_min;
    logic [VOLT_W-1:0] pack_max;
    logic [NCELL_W-1:0] reg_num_cells;
    logic [VOLT_W-1:0] reg_threshold;
    logic [VOLT_W-1:0] reg_min_balance;

    int unsigned cells_sent = 0;
    int unsigned decisions_seen = 0;
    int unsigned rounds_done = 0;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;
    bit          idle_enable = 1'b0;

    cell_balance_decider_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_cell_voltage   (i_cell_voltage),
        .o_valid          (o_valid),
        .o_cell_index     (o_cell_index),
        .o_discharge      (o_discharge),
        .o_min_voltage    (o_min_voltage),
        .o_max_voltage    (o_max_voltage),
        .o_discharge_mask (o_discharge_mask),
        .o_last_result    (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void balance_decide(input logic [VOLT_W-1:0] volts);
        int unsigned target;
        int unsigned k;
        logic [VOLT_W:0] limit;
        logic [MASK_W-1:0] mask;
        t_decision d;
        if (pack_loaded < NCELLS) begin
            pack_cells[pack_loaded] = volts;
        end
        if (volts < pack_min) begin
            pack_min = volts;
        end
        if (volts > pack_max) begin
            pack_max = volts;
        end
        if (pack_loaded < NCELLS) begin
            pack_loaded++;
        end
        target = (reg_num_cells == 0) ? 1 : (reg_num_cells > NCELLS) ? NCELLS : reg_num_cells;
        if (pack_loaded < target) begin
            return;
        end
        // The pack minimum plus the threshold is compared in 17 bits.
        limit = {1'b0, pack_min} + {1'b0, reg_threshold};
        mask = '0;
        for (k = 0; k < pack_loaded; k++) begin
            d.cell_index = k[NCELL_W-1:0];
            d.discharge = (pack_cells[k] > reg_min_balance) && ({1'b0, pack_cells[k]} > limit);
            if (k < MASK_W) begin
                mask[k] = d.discharge;
            end
            d.min_voltage = pack_min;
            d.max_voltage = pack_max;
            d.discharge_mask = mask;
            d.last_result = (k + 1 == pack_loaded);
            pending_decisions.push_back(d);
        end
        rounds_done++;
        pack_loaded = 0;
        pack_min = VOLT_ALL_ONES;
        pack_max = '0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected_v,
                                        input logic [31:0] actual_v);
        if (expected_v !== actual_v) begin
            $error("%s: expected %0d, got %0d", name, expected_v, actual_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_decisions
        t_decision want;
        if (i_rst_n && o_valid) begin
            decisions_seen++;
            if (pending_decisions.size() == 0) begin
                $error("Decision beat for cell %0d arrived with nothing expected", o_cell_index);
                error_count++;
            end else begin
                want = pending_decisions.pop_front();
                check_field("cell_index", want.cell_index, o_cell_index);
                check_field("discharge", want.discharge, o_discharge);
                check_field("min_voltage", want.min_voltage, o_min_voltage);
                check_field("max_voltage", want.max_voltage, o_max_voltage);
                check_field("discharge_mask", want.discharge_mask, o_discharge_mask);
                check_field("last_result", want.last_result, o_last_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $error("No beat accepted for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_cell(input logic [VOLT_W-1:0] volts);
        @(negedge i_clk);
        start <= 1'b1;
        i_cell_voltage <= volts;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        balance_decide(volts);
        cells_sent++;
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_CELLS: begin
                reg_num_cells = data[NCELL_W-1:0];
            end
            CFG_THRESHOLD: begin
                reg_threshold = data;
            end
            CFG_MIN_BAL: begin
                reg_min_balance = data;
            end
            default: begin
            end
        endcase
    endtask

    task automatic drain_results();
        while (pending_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        while (busy) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    task automatic test_default_round();
        logic [VOLT_W-1:0] volts[18];
        int unsigned i;
        volts = '{16'd3000, 16'd3010, 16'd3011, 16'd3001, 16'hFFFF, 16'd3005,
                  16'd3020, 16'd3009, 16'd4200, 16'd3010, 16'd3500, 16'd3000,
                  16'd3011, 16'd3999, 16'd3100, 16'd3010, 16'd3012, 16'hFFFF};
        for (i = 0; i < 18; i++) begin
            send_cell(volts[i]);
        end
        drain_results();
    endtask

    task automatic test_single_cell();
        write_reg(CFG_NUM_CELLS, 16'd0);
        send_cell(16'h0000);
        send_cell(16'hFFFF);
        drain_results();
    endtask

    task automatic test_threshold_overflow();
        write_reg(CFG_NUM_CELLS, 16'd2);
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_MIN_BAL, 16'd0);
        send_cell(16'hFFFE);
        send_cell(16'hFFFF);
        drain_results();
    endtask

    task automatic test_count_lowered();
        write_reg(CFG_NUM_CELLS, 16'hFFFF);
        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_MIN_BAL, 16'd4000);
        write_reg(CFG_SPARE, 16'hA5A5);
        send_cell(16'd3900);
        send_cell(16'd4000);
        send_cell(16'd4001);
        drain_results();
        write_reg(CFG_NUM_CELLS, 16'd2);
        send_cell(16'd4100);
        drain_results();
    endtask

    task automatic test_random_rounds();
        int unsigned item_goal;
        int unsigned phase_items;
        int unsigned base;
        int unsigned spread;
        bit wide_range;
        logic [CFG_DATA_W-1:0] data;
        logic [VOLT_W-1:0] volts;
        item_goal = cells_sent + RANDOM_CELLS;
        while (cells_sent < item_goal) begin
            drain_results();
            if ($urandom_range(0, 2) != 0) begin
                data = CFG_DATA_W'($urandom);
                case ($urandom_range(0, 9))
                    0: data[NCELL_W-1:0] = 5'd0;
                    1: data[NCELL_W-1:0] = 5'd18;
                    2: data[NCELL_W-1:0] = NCELL_W'($urandom_range(19, 31));
                    default: data[NCELL_W-1:0] = NCELL_W'($urandom_range(1, 8));
                endcase
                write_reg(CFG_NUM_CELLS, data);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: data = 16'h0000;
                    1: data = 16'hFFFF;
                    2: data = CFG_DATA_W'($urandom);
                    default: data = CFG_DATA_W'($urandom_range(0, 60));
                endcase
                write_reg(CFG_THRESHOLD, data);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: data = 16'h0000;
                    1: data = 16'hFFFF;
                    2: data = CFG_DATA_W'($urandom);
                    default: data = CFG_DATA_W'($urandom_range(2900, 4100));
                endcase
                write_reg(CFG_MIN_BAL, data);
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            end
            phase_items = $urandom_range(6, 30);
            if (phase_items > item_goal - cells_sent) begin
                phase_items = item_goal - cells_sent;
            end
            wide_range = ($urandom_range(0, 2) == 0);
            base = $urandom_range(2800, 4200);
            spread = $urandom_range(0, 60);
            repeat (phase_items) begin
                if (wide_range) begin
                    volts = VOLT_W'($urandom);
                end else begin
                    volts = VOLT_W'(base + $urandom_range(0, spread));
                end
                idle_enable = (cells_sent + 30 < item_goal);
                maybe_idle();
                send_cell(volts);
            end
        end
        idle_enable = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_NUM_CELLS;
        i_cfg_data = '0;
        start = 1'b0;
        i_cell_voltage = '0;
        pack_loaded = 0;
        pack_min = VOLT_ALL_ONES;
        pack_max = '0;
        reg_num_cells = NUM_CELLS_RST;
        reg_threshold = THRESHOLD_RST;
        reg_min_balance = MIN_BAL_RST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_round();
        test_single_cell();
        test_threshold_overflow();
        test_count_lowered();
        test_random_rounds();

        while (pending_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_decisions.size() != 0) begin
            $error("%0d expected decision beats never arrived", pending_decisions.size());
            error_count++;
        end

        $display("Sent %0d cell beats and checked %0d decision beats over %0d rounds.",
                 cells_sent, decisions_seen, rounds_done);
        $display("Cell counts from 0 to 31, mid-round count changes and limit extremes exercised.");
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
